@@ rtl/core/manchester_frame_transmitter_assert.svh @@
// Assertion macros for the Manchester frame transmitter.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef MANCHESTER_FRAME_TRANSMITTER_ASSERT_SVH
`define MANCHESTER_FRAME_TRANSMITTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mft_pkg.sv @@
`default_nettype none

package mft_pkg;

  localparam int CODE_IN_BITS = 32;
  localparam int CFG_BITS     = 16;
  localparam int CODE_BITS    = 32;
  localparam int TIMER_BITS   = 16;
  localparam int BIDX_BITS    = 6;

  localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

  localparam logic [CFG_BITS-1:0] HEADER_TICKS_RESET   = CFG_BITS'(500);
  localparam logic [CFG_BITS-1:0] HALF_BIT_TICKS_RESET = CFG_BITS'(250);
  localparam logic [CFG_BITS-1:0] GAP_TICKS_RESET      = CFG_BITS'(3333);

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [BIDX_BITS-1:0]  bidx_t;
  typedef logic [CODE_BITS-1:0]  word_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BITS   = 2'd2,
    PH_GAP    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REG_HEADER_TICKS   = 2'd0,
    REG_HALF_BIT_TICKS = 2'd1,
    REG_GAP_TICKS      = 2'd2,
    REG_INVERT_LINE    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] header_ticks;
    logic [CFG_BITS-1:0] half_bit_ticks;
    logic [CFG_BITS-1:0] gap_ticks;
    logic                invert_line;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic rejected;
    logic frame_done;
  } res_t;

  function automatic timer_t load_len(logic [CFG_BITS-1:0] v);
    logic [31:0] ext;
    ext = 32'(v);
    if (ext == 32'd0) begin
      return timer_t'(1);
    end else if (ext > TIMER_MAX) begin
      return timer_t'(TIMER_MAX);
    end
    return timer_t'(ext);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/mft_in_if.sv @@
`default_nettype none

interface mft_in_if;
  import mft_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [CODE_IN_BITS-1:0] code;

  modport source (output valid, output op, output code, input ready);
  modport sink   (input valid, input op, input code, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mft_out_if.sv @@
`default_nettype none

interface mft_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic rejected;
  logic frame_done;

  modport source (output valid, output line_level, output busy_res, output rejected,
                  output frame_done, input ready);
  modport sink   (input valid, input line_level, input busy_res, input rejected,
                  input frame_done, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mft_seq.sv @@
`default_nettype none

module mft_seq (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic                             op,
  input  logic [mft_pkg::CODE_IN_BITS-1:0] code,
  input  mft_pkg::cfg_t                    cfg,
  output mft_pkg::res_t                    res
);
  import mft_pkg::*;

  phase_t phase, phase_next;
  timer_t tick_count, tick_count_next;
  bidx_t  bit_index, bit_index_next;
  word_t  shift_word, shift_word_next;
  logic   second_half, second_half_next;
  logic   rejected, done;
  timer_t tick_dec;
  logic   lv;

  assign tick_dec = tick_count - timer_t'(1);

  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    bit_index_next   = bit_index;
    shift_word_next  = shift_word;
    second_half_next = second_half;
    rejected         = 1'b0;
    done             = 1'b0;
    if (accept) begin
      if (op) begin
        if (phase == PH_IDLE) begin
          shift_word_next  = word_t'(code);
          bit_index_next   = '0;
          second_half_next = 1'b0;
          phase_next       = PH_HEADER;
          tick_count_next  = load_len(cfg.header_ticks);
        end else begin
          rejected = 1'b1;
        end
      end else if (phase != PH_IDLE) begin
        tick_count_next = tick_dec;
        if (tick_dec == '0) begin
          unique case (phase)
            PH_HEADER: begin
              phase_next       = PH_BITS;
              bit_index_next   = '0;
              second_half_next = 1'b0;
              tick_count_next  = load_len(cfg.half_bit_ticks);
            end
            PH_BITS: begin
              if (!second_half) begin
                second_half_next = 1'b1;
                tick_count_next  = load_len(cfg.half_bit_ticks);
              end else if (bit_index >= bidx_t'(CODE_BITS - 1)) begin
                phase_next       = PH_GAP;
                second_half_next = 1'b0;
                tick_count_next  = load_len(cfg.gap_ticks);
              end else begin
                bit_index_next   = bit_index + bidx_t'(1);
                second_half_next = 1'b0;
                shift_word_next  = {shift_word[CODE_BITS-2:0], 1'b0};
                tick_count_next  = load_len(cfg.half_bit_ticks);
              end
            end
            PH_GAP: begin
              phase_next       = PH_IDLE;
              tick_count_next  = '0;
              bit_index_next   = '0;
              second_half_next = 1'b0;
              shift_word_next  = '0;
              done             = 1'b1;
            end
            PH_IDLE: begin
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    unique case (phase_next)
      PH_HEADER: lv = 1'b1;
      PH_BITS:   lv = shift_word_next[CODE_BITS-1] ^ second_half_next;
      PH_IDLE:   lv = 1'b0;
      PH_GAP:    lv = 1'b0;
    endcase
    res.line_level = lv ^ cfg.invert_line;
    res.busy_res   = (phase_next != PH_IDLE);
    res.rejected   = rejected;
    res.frame_done = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      tick_count  <= '0;
      bit_index   <= '0;
      shift_word  <= '0;
      second_half <= 1'b0;
    end else begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      bit_index   <= bit_index_next;
      shift_word  <= shift_word_next;
      second_half <= second_half_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/manchester_frame_transmitter.sv @@
// Channel  Dir  Fields                                     Handshake
// req      in   op, code[31:0]                             valid/ready
// res      out  line_level, busy_res, rejected, frame_done valid/ready
// cfg      in   cfg_index[1:0], cfg_data[15:0]             cfg_wr_en, no wait
//
// One word is taken per clock while req.ready is high; its result is registered before it leaves on res.
// The frame sequencer updates in the cycle a word is accepted.
// A two-entry output buffer keeps req ready while one result waits on res.
// req.ready drops only when both output entries are full.
// Reset restores register defaults and an idle, low line.
`default_nettype none

module manchester_frame_transmitter (
  input  logic                         clk,
  input  logic                         rst,
  mft_in_if.sink                       req,
  mft_out_if.source                    res,
  input  logic                         cfg_wr_en,
  input  logic [1:0]                   cfg_index,
  input  logic [mft_pkg::CFG_BITS-1:0] cfg_data
);
  import mft_pkg::*;

  cfg_t cfg;
  res_t seq_res;
  res_t out_word, skid_word;
  logic out_valid, skid_valid;
  logic push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_ticks   <= HEADER_TICKS_RESET;
      cfg.half_bit_ticks <= HALF_BIT_TICKS_RESET;
      cfg.gap_ticks      <= GAP_TICKS_RESET;
      cfg.invert_line    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_HEADER_TICKS:   cfg.header_ticks   <= cfg_data;
        REG_HALF_BIT_TICKS: cfg.half_bit_ticks <= cfg_data;
        REG_GAP_TICKS:      cfg.gap_ticks      <= cfg_data;
        REG_INVERT_LINE:    cfg.invert_line    <= cfg_data[0];
      endcase
    end
  end

  assign req.ready = !skid_valid;
  assign push      = req.valid && req.ready;
  assign pop       = out_valid && res.ready;

  mft_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (push),
    .op     (req.op),
    .code   (req.code),
    .cfg    (cfg),
    .res    (seq_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (pop || !out_valid) begin
        out_valid <= push;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_word <= skid_word;
      end
    end else if (pop || !out_valid) begin
      out_word <= seq_res;
    end else begin
      skid_word <= seq_res;
    end
  end

  assign res.valid      = out_valid;
  assign res.line_level = out_word.line_level;
  assign res.busy_res   = out_word.busy_res;
  assign res.rejected   = out_word.rejected;
  assign res.frame_done = out_word.frame_done;

`include "manchester_frame_transmitter_assert.svh"

  `MFT_ASSERT_SAME(a_skid_needs_head, skid_valid, out_valid, "skid entry without head entry")
  `MFT_ASSERT_NEXT(a_stall_fills_skid, push && out_valid && !res.ready && !skid_valid, skid_valid, "stalled result lost")
  `MFT_ASSERT_SAME(a_done_goes_idle, push && seq_res.frame_done, !seq_res.busy_res, "frame end while busy")
  `MFT_ASSERT_SAME(a_reject_when_busy, push && seq_res.rejected, seq_res.busy_res && !seq_res.frame_done, "reject while idle")

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import mft_pkg::*;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;
  localparam int FRAME_ROW = 2;
  localparam int SCRIPT_ROWS = 9;
  localparam int PLAN_COUNT = 4;

  typedef struct {
    logic        op;
    logic [31:0] code;
    bit          fixed;
    res_t        want;
  } script_row_t;

  typedef struct {
    logic [CFG_BITS-1:0] header;
    logic [CFG_BITS-1:0] half;
    logic [CFG_BITS-1:0] gap;
    logic                inv;
    int                  send_idle;
    int                  stall;
    int                  count;
  } phase_plan_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  mft_in_if req_if ();
  mft_out_if res_if ();

  manchester_frame_transmitter dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .res(res_if),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cfg_t   shadow_cfg;
  phase_t tx_phase;
  timer_t tx_left;
  bidx_t  tx_bit;
  word_t  tx_shift;
  logic   tx_second;

  res_t level_queue[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Each row's want is packed as {line_level, busy_res, rejected, frame_done}.
  script_row_t script [SCRIPT_ROWS] = '{
    '{OP_TICK, 32'h0000_0000, 1'b1, 4'b0000},
    '{OP_TICK, 32'hFFFF_FFFF, 1'b1, 4'b0000},
    '{OP_TICK, 32'h0000_0000, 1'b1, 4'b1000},
    '{OP_SEND, 32'hFFFF_FFFF, 1'b1, 4'b0100},
    '{OP_SEND, 32'h0000_0000, 1'b1, 4'b0110},
    '{OP_TICK, 32'h0000_0000, 1'b0, 4'b0000},
    '{OP_TICK, 32'hFFFF_FFFF, 1'b0, 4'b0000},
    '{OP_SEND, 32'hAAAA_5555, 1'b0, 4'b0000},
    '{OP_TICK, 32'h0000_0000, 1'b0, 4'b0000}
  };

  phase_plan_t plans [PLAN_COUNT] = '{
    '{16'd1, 16'd1, 16'd1, 1'b0, 0, 0, 200},
    '{16'd3, 16'd2, 16'd4, 1'b1, 76, 0, 200},
    '{16'd5, 16'd1, 16'd2, 1'b0, 0, 76, 200},
    '{16'd2, 16'd3, 16'd1, 1'b1, 14, 14, 200}
  };

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = ~clk;
  end

  function automatic timer_t span_ticks(logic [CFG_BITS-1:0] v);
    if (v == '0) begin
      return timer_t'(1);
    end
    return timer_t'(v);
  endfunction

  function automatic res_t step_line(logic op, logic [31:0] code);
    res_t r;
    logic lv;
    r = '0;
    if (op == OP_SEND) begin
      if (tx_phase == PH_IDLE) begin
        tx_shift = word_t'(code);
        tx_bit = '0;
        tx_second = 1'b0;
        tx_phase = PH_HEADER;
        tx_left = span_ticks(shadow_cfg.header_ticks);
      end else begin
        r.rejected = 1'b1;
      end
    end else if (tx_phase != PH_IDLE) begin
      tx_left = tx_left - 1'b1;
      if (tx_left == '0) begin
        case (tx_phase)
          PH_HEADER: begin
            tx_phase = PH_BITS;
            tx_bit = '0;
            tx_second = 1'b0;
            tx_left = span_ticks(shadow_cfg.half_bit_ticks);
          end
          PH_BITS: begin
            if (!tx_second) begin
              tx_second = 1'b1;
              tx_left = span_ticks(shadow_cfg.half_bit_ticks);
            end else if (tx_bit >= CODE_BITS - 1) begin
              tx_phase = PH_GAP;
              tx_second = 1'b0;
              tx_left = span_ticks(shadow_cfg.gap_ticks);
            end else begin
              tx_bit = tx_bit + 1'b1;
              tx_second = 1'b0;
              tx_shift = tx_shift << 1;
              tx_left = span_ticks(shadow_cfg.half_bit_ticks);
            end
          end
          PH_GAP: begin
            tx_phase = PH_IDLE;
            tx_left = '0;
            tx_bit = '0;
            tx_second = 1'b0;
            tx_shift = '0;
            r.frame_done = 1'b1;
          end
          default: ;
        endcase
      end
    end
    lv = 1'b0;
    if (tx_phase == PH_HEADER) begin
      lv = 1'b1;
    end else if (tx_phase == PH_BITS) begin
      lv = tx_shift[CODE_BITS-1] ^ tx_second;
    end
    r.line_level = lv ^ shadow_cfg.invert_line;
    r.busy_res = (tx_phase != PH_IDLE);
    return r;
  endfunction

  task automatic put_word(input logic op, input logic [31:0] code, input bit fixed,
                          input res_t want);
    res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.op <= op;
    req_if.code <= code;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    r = step_line(op, code);
    level_queue.push_back(fixed ? want : r);
  endtask

  task automatic put_random_word();
    logic op;
    op = ($urandom_range(99) < 12) ? OP_SEND : OP_TICK;
    put_word(op, $urandom, 1'b0, '0);
  endtask

  task automatic finish_frame();
    while (tx_phase != PH_IDLE) begin
      put_word(OP_TICK, $urandom, 1'b0, '0);
    end
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    while (level_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_BITS-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      REG_HEADER_TICKS:   shadow_cfg.header_ticks = v;
      REG_HALF_BIT_TICKS: shadow_cfg.half_bit_ticks = v;
      REG_GAP_TICKS:      shadow_cfg.gap_ticks = v;
      REG_INVERT_LINE:    shadow_cfg.invert_line = v[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [CFG_BITS-1:0] h, input logic [CFG_BITS-1:0] hb,
                               input logic [CFG_BITS-1:0] g, input logic inv);
    write_reg(REG_HEADER_TICKS, h);
    write_reg(REG_HALF_BIT_TICKS, hb);
    write_reg(REG_GAP_TICKS, g);
    write_reg(REG_INVERT_LINE, {{(CFG_BITS-1){1'b0}}, inv});
    cfg_wr_en <= 1'b0;
  endtask

  task automatic report_miss(input string what, input res_t want, input res_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display({"%s at %0t: expected level=%0b busy=%0b rejected=%0b done=%0b, ",
                "got level=%0b busy=%0b rejected=%0b done=%0b"},
               what, $realtime, want.line_level, want.busy_res, want.rejected,
               want.frame_done, got.line_level, got.busy_res, got.rejected, got.frame_done);
    end
  endtask

  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_levels
    res_t got;
    res_t want;
    if (!rst && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got.line_level = res_if.line_level;
      got.busy_res = res_if.busy_res;
      got.rejected = res_if.rejected;
      got.frame_done = res_if.frame_done;
      if (level_queue.size() == 0) begin
        report_miss("Unexpected word", '0, got);
      end else begin
        want = level_queue.pop_front();
        if (got.line_level !== want.line_level || got.busy_res !== want.busy_res ||
            got.rejected !== want.rejected || got.frame_done !== want.frame_done) begin
          report_miss("Mismatch", want, got);
        end
      end
    end
  end

  initial begin
    #400_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.op = OP_TICK;
    req_if.code = '0;
    res_if.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_HEADER_TICKS;
    cfg_data = '0;
    shadow_cfg = '{HEADER_TICKS_RESET, HALF_BIT_TICKS_RESET, GAP_TICKS_RESET, 1'b0};
    tx_phase = PH_IDLE;
    tx_left = '0;
    tx_bit = '0;
    tx_shift = '0;
    tx_second = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero lengths behave as one tick, so the directed frame stays short.
    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      if (i == FRAME_ROW) begin
        settle();
        load_settings('0, '0, '0, 1'b1);
      end
      put_word(script[i].op, script[i].code, script[i].fixed, script[i].want);
    end
    finish_frame();
    settle();

    for (int p = 0; p < PLAN_COUNT; p++) begin
      send_idle_pct = plans[p].send_idle;
      recv_stall_pct = plans[p].stall;
      load_settings(plans[p].header, plans[p].half, plans[p].gap, plans[p].inv);
      repeat (plans[p].count) put_random_word();
      finish_frame();
      settle();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;

    // The longest half bit cell is only entered, not completed.
    load_settings(16'd2, 16'hFFFF, 16'd3, 1'b0);
    put_word(OP_SEND, $urandom, 1'b0, '0);
    repeat (60) put_random_word();
    settle();

    if (fail_count == 0 && level_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
